// ----- hw/rtl/b64c_pkg.sv -----
// Shared types, codes and alphabet functions for the base64url stream codec.
package b64c_pkg;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic [1:0] STATUS_OK            = 2'd0;
	localparam logic [1:0] STATUS_INVALID       = 2'd1;
	localparam logic [1:0] STATUS_NONCANONICAL  = 2'd2;

	localparam logic [7:0] CHAR_PAD   = 8'h3d;	// '='
	localparam logic [7:0] CHAR_DASH  = 8'h2d;	// '-'
	localparam logic [7:0] CHAR_UNDER = 8'h5f;	// '_'
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
	localparam logic [7:0] CHAR_LO_A  = 8'h61;
	localparam logic [7:0] CHAR_LO_Z  = 8'h7a;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	typedef struct packed {
		logic [7:0] symbol;
		logic       is_last;
	} b64c_in_t;

	typedef struct packed {
		logic [7:0] out_value;
		logic       value_present;
		logic       end_of_run;
		logic [1:0] status;
	} b64c_out_t;

	// Sextet to alphabet character.
	function automatic logic [7:0] char_of(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)
			return w + CHAR_UP_A;
		else if (v < 6'd52)
			return w + (CHAR_LO_A - 8'd26);
		else if (v < 6'd62)
			return w - (8'd52 - CHAR_ZERO);
		else if (v == 6'd62)
			return CHAR_DASH;
		else
			return CHAR_UNDER;
	endfunction

	// Character to sextet; bit 6 set means the character is not in the alphabet.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		if (c >= CHAR_UP_A && c <= CHAR_UP_Z)
			return {1'b0, 6'(c - CHAR_UP_A)};
		else if (c >= CHAR_LO_A && c <= CHAR_LO_Z)
			return {1'b0, 6'(c - CHAR_LO_A + 8'd26)};
		else if (c >= CHAR_ZERO && c <= CHAR_NINE)
			return {1'b0, 6'(c - CHAR_ZERO + 8'd52)};
		else if (c == CHAR_DASH)
			return 7'd62;
		else if (c == CHAR_UNDER)
			return 7'd63;
		else
			return 7'h40;
	endfunction

endpackage

// ----- hw/rtl/base64url_stream_codec_core.sv -----
// Unpadded base64url codec core: input register, codec logic, two-slot result register.
// An accepted item is held in an input register and is worked into a two-slot result
// register. Items that give zero or one result go through at one per cycle while
// out_ready holds; an encoded byte that yields two characters (every third byte, or a
// last byte that needs a flush character) holds the input stage until the second one
// is taken, since the single result port drains one result per cycle. The direction
// register (0 encode, 1 decode) is written through the cfg port, which is always ready;
// a write also clears any partial string. In decode mode the final result of a string
// carries the status (ok, invalid, non-canonical); bytes already emitted for a string
// whose final status is not ok should be discarded downstream.
module base64url_stream_codec_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  b64c_pkg::b64c_in_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output b64c_pkg::b64c_out_t out_item
);

	logic                dir_q;
	logic                s1_valid_q;
	b64c_pkg::b64c_in_t  s1_item_s1;
	b64c_pkg::b64c_out_t res0_s2, res1_s2;
	logic [1:0]          res_cnt_q;

	logic [5:0] acc_q, acc_nx;
	logic [2:0] pend_q, pend_nx;
	logic [1:0] len_q, len_nx;
	logic       pad_q, pad_nx, bad_q, bad_nx;

	logic                s1_adv, pop;
	b64c_pkg::b64c_out_t r0, r1;
	logic [1:0]          n_res;

	logic [11:0] enc_acc, dec_acc;
	logic [5:0]  ch0, ch1;
	logic        two;
	logic [6:0]  sx;
	logic [7:0]  dbyte;
	logic        dpres, tail_nz;
	logic [1:0]  dstat;

	assign cfg_ready = 1'b1;
	assign out_valid = (res_cnt_q != 2'd0);
	assign out_item  = res0_s2;
	assign pop       = out_valid && out_ready;
	assign s1_adv    = s1_valid_q && ((res_cnt_q == 2'd0) || (res_cnt_q == 2'd1 && pop));
	assign in_ready  = !s1_valid_q || s1_adv;

	always_comb begin
		acc_nx  = acc_q;
		pend_nx = pend_q;
		len_nx  = len_q;
		pad_nx  = pad_q;
		bad_nx  = bad_q;
		r0      = '0;
		r1      = '0;
		n_res   = 2'd0;
		enc_acc = {acc_q[3:0], s1_item_s1.symbol};
		dec_acc = '0;
		ch0     = '0;
		ch1     = '0;
		two     = 1'b0;
		sx      = b64c_pkg::sextet_of(s1_item_s1.symbol);
		dbyte   = '0;
		dpres   = 1'b0;
		tail_nz = 1'b0;
		dstat   = b64c_pkg::STATUS_OK;

		if (dir_q == b64c_pkg::DIR_ENCODE) begin
			// ch1 is either the second full sextet or the zero-padded flush
			case (pend_q)
				3'd0: begin
					ch0     = enc_acc[7:2];
					ch1     = {enc_acc[1:0], 4'b0000};
					two     = s1_item_s1.is_last;
					pend_nx = 3'd2;
				end
				3'd2: begin
					ch0     = enc_acc[9:4];
					ch1     = {enc_acc[3:0], 2'b00};
					two     = s1_item_s1.is_last;
					pend_nx = 3'd4;
				end
				default: begin
					ch0     = enc_acc[11:6];
					ch1     = enc_acc[5:0];
					two     = 1'b1;
					pend_nx = 3'd0;
				end
			endcase
			acc_nx           = s1_item_s1.symbol[5:0];
			r0.out_value     = b64c_pkg::char_of(ch0);
			r0.value_present = 1'b1;
			r0.end_of_run    = s1_item_s1.is_last && !two;
			r1.out_value     = b64c_pkg::char_of(ch1);
			r1.value_present = 1'b1;
			r1.end_of_run    = s1_item_s1.is_last;
			n_res            = two ? 2'd2 : 2'd1;
		end else begin
			len_nx = len_q + 2'd1;
			if (s1_item_s1.symbol == b64c_pkg::CHAR_PAD) begin
				pad_nx = 1'b1;
			end else if (sx[6]) begin
				bad_nx = 1'b1;
			end else begin
				dec_acc = {acc_q, sx[5:0]};
				acc_nx  = sx[5:0];
				case (pend_q)
					3'd0: begin
						pend_nx = 3'd6;
					end
					3'd2: begin
						dbyte   = dec_acc[7:0];
						dpres   = 1'b1;
						pend_nx = 3'd0;
					end
					3'd4: begin
						dbyte   = dec_acc[9:2];
						dpres   = 1'b1;
						pend_nx = 3'd2;
					end
					default: begin
						dbyte   = dec_acc[11:4];
						dpres   = 1'b1;
						pend_nx = 3'd4;
					end
				endcase
			end
			// leftover bits that never made a byte must be zero
			case (pend_nx)
				3'd0:    tail_nz = 1'b0;
				3'd2:    tail_nz = (acc_nx[1:0] != 2'd0);
				3'd4:    tail_nz = (acc_nx[3:0] != 4'd0);
				default: tail_nz = (acc_nx != 6'd0);
			endcase
			if (pad_nx)
				dstat = b64c_pkg::STATUS_NONCANONICAL;
			else if (len_nx == 2'd1 || bad_nx)
				dstat = b64c_pkg::STATUS_INVALID;
			else if (tail_nz)
				dstat = b64c_pkg::STATUS_NONCANONICAL;
			r0.out_value     = dbyte;
			r0.value_present = dpres;
			r0.end_of_run    = s1_item_s1.is_last;
			r0.status        = s1_item_s1.is_last ? dstat : b64c_pkg::STATUS_OK;
			n_res            = (dpres || s1_item_s1.is_last) ? 2'd1 : 2'd0;
		end

		if (s1_item_s1.is_last) begin
			acc_nx  = '0;
			pend_nx = '0;
			len_nx  = '0;
			pad_nx  = 1'b0;
			bad_nx  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q      <= b64c_pkg::DIR_ENCODE;
			s1_valid_q <= 1'b0;
			res_cnt_q  <= 2'd0;
			acc_q      <= '0;
			pend_q     <= '0;
			len_q      <= '0;
			pad_q      <= 1'b0;
			bad_q      <= 1'b0;
		end else begin
			if (in_ready)
				s1_valid_q <= in_valid;
			if (s1_adv)
				res_cnt_q <= n_res;
			else if (pop)
				res_cnt_q <= res_cnt_q - 2'd1;
			if (cfg_valid && cfg_ready) begin
				dir_q  <= cfg_data;
				acc_q  <= '0;
				pend_q <= '0;
				len_q  <= '0;
				pad_q  <= 1'b0;
				bad_q  <= 1'b0;
			end else if (s1_adv) begin
				acc_q  <= acc_nx;
				pend_q <= pend_nx;
				len_q  <= len_nx;
				pad_q  <= pad_nx;
				bad_q  <= bad_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			s1_item_s1 <= in_item;
		if (s1_adv) begin
			res0_s2 <= r0;
			res1_s2 <= r1;
		end else if (pop) begin
			res0_s2 <= res1_s2;
		end
	end

endmodule

// ----- hw/rtl/b64c_checker.sv -----
// Port-level checker for the base64url stream codec core, with its bind.
module b64c_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic                cfg_data,
	input logic                out_valid,
	input logic                out_ready,
	input b64c_pkg::b64c_out_t out_item
);

	logic dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dir_q <= b64c_pkg::DIR_ENCODE;
		else if (cfg_valid && cfg_ready)
			dir_q <= cfg_data;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.value_present |->
			out_item.end_of_run && out_item.out_value == 8'd0)
		else $error("empty result item that is not a clean final item");

	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.end_of_run |-> out_item.status == b64c_pkg::STATUS_OK)
		else $error("status set on a non-final item");

	a_encode_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dir_q == b64c_pkg::DIR_ENCODE |->
			out_item.value_present && out_item.status == b64c_pkg::STATUS_OK)
		else $error("encode result item without character or with status");

endmodule

bind base64url_stream_codec_core b64c_checker u_b64c_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_data  (cfg_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
